@@ rtl/core/selection_bitmap_limit_compact_assert.svh @@
`ifndef SELECTION_BITMAP_LIMIT_COMPACT_ASSERT_SVH
`define SELECTION_BITMAP_LIMIT_COMPACT_ASSERT_SVH

// same-cycle implication under reset
`define SBLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define SBLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sblc_pkg.sv @@
`timescale 1ns / 1ps
package sblc_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned BIT_CNT_W  = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;
  localparam logic [POS_W-1:0] LAST_POS = 13'd8191;

  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_SELECT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_EMIT_INDICES = 2'd2;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_INDEX   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row_count;
    logic [ROW_W-1:0] select_limit;
    logic             emit_indices;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] kept_byte;
    logic [POS_W-1:0]     base;
    logic                 emit;
    logic                 last;
    logic [ROW_W-1:0]     total;
    logic                 all_sel;
  } entry_t;

  typedef enum logic [2:0] {
    PH_BYTE  = 3'b001,
    PH_INDEX = 3'b010,
    PH_SUM   = 3'b100
  } phase_t;

endpackage

@@ rtl/core/sblc_front.sv @@
`timescale 1ns / 1ps
module sblc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sblc_pkg::cfg_t                        cfg,
  input  logic                                  in_push,
  input  logic [sblc_pkg::BYTE_BITS-1:0]        in_bitmap_byte,
  input  logic                                  in_last,
  input  logic                                  fifo_full,
  output logic                                  wr_en,
  output sblc_pkg::entry_t                      wr_entry
);

  logic [sblc_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [sblc_pkg::ROW_W-1:0]     budget_r, budget_nxt;
  logic [sblc_pkg::ROW_W-1:0]     total_r, total_nxt;

  logic [sblc_pkg::ROW_W-1:0]     budget_cur;
  logic [sblc_pkg::POS_W-1:0]     rc_hi;
  logic [sblc_pkg::BYTE_BITS-1:0] valid_mask;
  logic [sblc_pkg::BYTE_BITS-1:0] masked;
  logic [sblc_pkg::BYTE_BITS-1:0] kept;
  logic [sblc_pkg::BIT_CNT_W-1:0] cnt;
  logic [sblc_pkg::ROW_W:0]       sum;
  logic [sblc_pkg::ROW_W-1:0]     total_new;

  assign wr_en      = in_push && !fifo_full;
  assign budget_cur = (pos_r == '0) ? cfg.select_limit : budget_r;
  assign rc_hi      = cfg.row_count[sblc_pkg::ROW_W-1:sblc_pkg::BIT_IDX_W];

  always_comb begin
    valid_mask = '0;
    if (!ovf_r) begin
      if (pos_r < rc_hi) begin
        valid_mask = '1;
      end else if (pos_r == rc_hi) begin
        for (int i = 0; i < sblc_pkg::BYTE_BITS; i++) begin
          valid_mask[i] = sblc_pkg::BIT_IDX_W'(i) < cfg.row_count[sblc_pkg::BIT_IDX_W-1:0];
        end
      end
    end
  end

  assign masked = in_bitmap_byte & valid_mask;

  // keep set bits lowest row first while budget remains
  always_comb begin
    kept = '0;
    cnt  = '0;
    for (int i = 0; i < sblc_pkg::BYTE_BITS; i++) begin
      if (masked[i] && (budget_cur > sblc_pkg::ROW_W'(cnt))) begin
        kept[i] = 1'b1;
        cnt     = cnt + 1'b1;
      end
    end
  end

  assign sum       = {1'b0, total_r} + (sblc_pkg::ROW_W + 1)'(cnt);
  assign total_new = sum[sblc_pkg::ROW_W] ? '1 : sum[sblc_pkg::ROW_W-1:0];

  always_comb begin
    wr_entry.kept_byte = kept;
    wr_entry.base      = pos_r;
    wr_entry.emit      = cfg.emit_indices;
    wr_entry.last      = in_last;
    wr_entry.total     = total_new;
    wr_entry.all_sel   = total_new == cfg.row_count;
  end

  always_comb begin
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    budget_nxt = budget_r;
    total_nxt  = total_r;
    if (wr_en) begin
      budget_nxt = budget_cur - sblc_pkg::ROW_W'(cnt);
      if (in_last) begin
        pos_nxt   = '0;
        ovf_nxt   = 1'b0;
        total_nxt = '0;
      end else begin
        total_nxt = total_new;
        if (pos_r < sblc_pkg::LAST_POS) begin
          pos_nxt = pos_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ovf_r    <= 1'b0;
      budget_r <= '1;
      total_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
      budget_r <= budget_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

@@ rtl/core/sblc_fifo.sv @@
`timescale 1ns / 1ps
module sblc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sblc_pkg::entry_t wr_entry,
  input  logic             rd_en,
  output sblc_pkg::entry_t rd_entry,
  output logic             full,
  output logic             empty
);

  sblc_pkg::entry_t mem [sblc_pkg::FIFO_DEPTH];

  logic [sblc_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sblc_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sblc_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic                         do_wr, do_rd;

  assign full     = count_r == sblc_pkg::FIFO_CW'(sblc_pkg::FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + sblc_pkg::FIFO_CW'(do_wr) - sblc_pkg::FIFO_CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/sblc_back.sv @@
`timescale 1ns / 1ps
module sblc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sblc_pkg::entry_t                      head,
  input  logic                                  fifo_empty,
  output logic                                  fifo_pop,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [1:0]                            out_kind,
  output logic [sblc_pkg::BYTE_BITS-1:0]        out_kept_byte,
  output logic [sblc_pkg::ROW_W-1:0]            out_row_index,
  output logic [sblc_pkg::ROW_W-1:0]            out_selected_count,
  output logic                                  out_any_selected,
  output logic                                  out_all_selected,
  output logic                                  out_end_of_run
);

  sblc_pkg::phase_t               phase_r, phase_nxt;
  logic [sblc_pkg::BYTE_BITS-1:0] rem_r, rem_nxt;
  logic                           valid_r, valid_nxt;
  logic [1:0]                     kind_r, kind_nxt;
  logic [sblc_pkg::BYTE_BITS-1:0] kbyte_r, kbyte_nxt;
  logic [sblc_pkg::ROW_W-1:0]     ridx_r, ridx_nxt;
  logic [sblc_pkg::ROW_W-1:0]     cnt_r, cnt_nxt;
  logic                           any_r, any_nxt;
  logic                           all_r, all_nxt;
  logic                           eor_r, eor_nxt;

  logic                           step;
  logic [sblc_pkg::BIT_IDX_W-1:0] low_idx;
  logic [sblc_pkg::BYTE_BITS-1:0] rem_clr;
  logic                           has_idx;

  assign step    = !fifo_empty && (!valid_r || out_pop);
  assign has_idx = head.emit && (head.kept_byte != '0);
  assign rem_clr = rem_r & (rem_r - 1'b1);

  always_comb begin
    low_idx = '0;
    for (int i = sblc_pkg::BYTE_BITS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = sblc_pkg::BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    valid_nxt = valid_r && !out_pop;
    kind_nxt  = kind_r;
    kbyte_nxt = kbyte_r;
    ridx_nxt  = ridx_r;
    cnt_nxt   = cnt_r;
    any_nxt   = any_r;
    all_nxt   = all_r;
    eor_nxt   = eor_r;
    fifo_pop  = 1'b0;
    if (step) begin
      valid_nxt = 1'b1;
      kbyte_nxt = '0;
      ridx_nxt  = '0;
      cnt_nxt   = '0;
      any_nxt   = 1'b0;
      all_nxt   = 1'b0;
      unique case (phase_r)
        sblc_pkg::PH_BYTE: begin
          kind_nxt  = sblc_pkg::KIND_BYTE;
          kbyte_nxt = head.kept_byte;
          eor_nxt   = !has_idx && !head.last;
          rem_nxt   = head.kept_byte;
          if (has_idx) begin
            phase_nxt = sblc_pkg::PH_INDEX;
          end else if (head.last) begin
            phase_nxt = sblc_pkg::PH_SUM;
          end else begin
            fifo_pop = 1'b1;
          end
        end
        sblc_pkg::PH_INDEX: begin
          kind_nxt = sblc_pkg::KIND_INDEX;
          ridx_nxt = {head.base, low_idx};
          rem_nxt  = rem_clr;
          eor_nxt  = (rem_clr == '0) && !head.last;
          if (rem_clr == '0) begin
            if (head.last) begin
              phase_nxt = sblc_pkg::PH_SUM;
            end else begin
              phase_nxt = sblc_pkg::PH_BYTE;
              fifo_pop  = 1'b1;
            end
          end
        end
        sblc_pkg::PH_SUM: begin
          kind_nxt  = sblc_pkg::KIND_SUMMARY;
          cnt_nxt   = head.total;
          any_nxt   = head.total != '0;
          all_nxt   = head.all_sel;
          eor_nxt   = 1'b1;
          phase_nxt = sblc_pkg::PH_BYTE;
          fifo_pop  = 1'b1;
        end
        default: begin
          phase_nxt = sblc_pkg::PH_BYTE;
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sblc_pkg::PH_BYTE;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    kind_r  <= kind_nxt;
    kbyte_r <= kbyte_nxt;
    ridx_r  <= ridx_nxt;
    cnt_r   <= cnt_nxt;
    any_r   <= any_nxt;
    all_r   <= all_nxt;
    eor_r   <= eor_nxt;
  end

  assign out_empty          = !valid_r;
  assign out_kind           = kind_r;
  assign out_kept_byte      = kbyte_r;
  assign out_row_index      = ridx_r;
  assign out_selected_count = cnt_r;
  assign out_any_selected   = any_r;
  assign out_all_selected   = all_r;
  assign out_end_of_run     = eor_r;

endmodule

@@ rtl/core/selection_bitmap_limit_compact.sv @@
`timescale 1ns / 1ps
// channel | handshake          | payload
// in      | in_push / in_full  | in_bitmap_byte, in_last
// out     | out_pop / out_empty| out_kind, out_kept_byte, out_row_index, out_selected_count,
//         |                    | out_any_selected, out_all_selected, out_end_of_run
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A byte yields one byte word on the result side, then one index word per kept row when
// indices are on, plus a summary word after a last byte; the output register holds one
// result, and the back end steps only while that register is empty or being popped.
// The front takes one byte per cycle while the 4-entry queue has room.
// Reset is synchronous, active low; cfg_ready is always high.
module selection_bitmap_limit_compact (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [sblc_pkg::BYTE_BITS-1:0]        in_bitmap_byte,
  input  logic                                  in_last,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [1:0]                            out_kind,
  output logic [sblc_pkg::BYTE_BITS-1:0]        out_kept_byte,
  output logic [sblc_pkg::ROW_W-1:0]            out_row_index,
  output logic [sblc_pkg::ROW_W-1:0]            out_selected_count,
  output logic                                  out_any_selected,
  output logic                                  out_all_selected,
  output logic                                  out_end_of_run,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [sblc_pkg::ROW_W-1:0]            cfg_data
);

  sblc_pkg::cfg_t   cfg_r, cfg_nxt;
  sblc_pkg::entry_t wr_entry;
  sblc_pkg::entry_t head;
  logic             wr_en;
  logic             fifo_full;
  logic             fifo_empty;
  logic             fifo_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = fifo_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sblc_pkg::CFG_ROW_COUNT:    cfg_nxt.row_count    = cfg_data;
        sblc_pkg::CFG_SELECT_LIMIT: cfg_nxt.select_limit = cfg_data;
        sblc_pkg::CFG_EMIT_INDICES: cfg_nxt.emit_indices = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count    <= '0;
      cfg_r.select_limit <= '1;
      cfg_r.emit_indices <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sblc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_bitmap_byte (in_bitmap_byte),
    .in_last        (in_last),
    .fifo_full      (fifo_full),
    .wr_en          (wr_en),
    .wr_entry       (wr_entry)
  );

  sblc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (fifo_pop),
    .rd_entry (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  sblc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .fifo_empty         (fifo_empty),
    .fifo_pop           (fifo_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_kept_byte      (out_kept_byte),
    .out_row_index      (out_row_index),
    .out_selected_count (out_selected_count),
    .out_any_selected   (out_any_selected),
    .out_all_selected   (out_all_selected),
    .out_end_of_run     (out_end_of_run)
  );

endmodule

@@ rtl/core/sblc_checker.sv @@
`timescale 1ns / 1ps
`include "selection_bitmap_limit_compact_assert.svh"
module sblc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [1:0]                     out_kind,
  input logic [sblc_pkg::BYTE_BITS-1:0] out_kept_byte,
  input logic [sblc_pkg::ROW_W-1:0]     out_row_index,
  input logic [sblc_pkg::ROW_W-1:0]     out_selected_count,
  input logic                           out_any_selected,
  input logic                           out_end_of_run
);

  `SBLC_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_kind) && $stable(out_row_index), "stalled word changed")
  `SBLC_ASSERT_NOW(a_sum_ends, clk, rst_n, !out_empty && out_kind == sblc_pkg::KIND_SUMMARY, out_end_of_run, "summary without end of run")
  `SBLC_ASSERT_NOW(a_sum_any, clk, rst_n, !out_empty && out_kind == sblc_pkg::KIND_SUMMARY, out_any_selected == (out_selected_count != '0), "any flag disagrees with count")
  `SBLC_ASSERT_NOW(a_idx_clean, clk, rst_n, !out_empty && out_kind == sblc_pkg::KIND_INDEX, out_kept_byte == '0 && out_selected_count == '0, "index word carries stray fields")

endmodule

bind selection_bitmap_limit_compact sblc_checker u_sblc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_kind           (out_kind),
  .out_kept_byte      (out_kept_byte),
  .out_row_index      (out_row_index),
  .out_selected_count (out_selected_count),
  .out_any_selected   (out_any_selected),
  .out_end_of_run     (out_end_of_run)
);

@@ verif/selection_bitmap_limit_compact_tb.sv @@
`timescale 1ns / 1ps
module selection_bitmap_limit_compact_tb;

  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [sblc_pkg::BYTE_BITS-1:0] bits;
    logic                           last;
  } bitmap_word_t;

  typedef struct packed {
    logic [1:0]                     kind;
    logic [sblc_pkg::BYTE_BITS-1:0] kept_byte;
    logic [sblc_pkg::ROW_W-1:0]     row_index;
    logic [sblc_pkg::ROW_W-1:0]     selected_count;
    logic                           any_selected;
    logic                           all_selected;
    logic                           end_of_run;
  } compact_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  logic                           in_full;
  logic [sblc_pkg::BYTE_BITS-1:0] in_bitmap_byte = '0;
  logic                           in_last = 1'b0;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic [1:0]                     out_kind;
  logic [sblc_pkg::BYTE_BITS-1:0] out_kept_byte;
  logic [sblc_pkg::ROW_W-1:0]     out_row_index;
  logic [sblc_pkg::ROW_W-1:0]     out_selected_count;
  logic                           out_any_selected;
  logic                           out_all_selected;
  logic                           out_end_of_run;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index = '0;
  logic [sblc_pkg::ROW_W-1:0]     cfg_data = '0;

  selection_bitmap_limit_compact uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_bitmap_byte     (in_bitmap_byte),
    .in_last            (in_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_kept_byte      (out_kept_byte),
    .out_row_index      (out_row_index),
    .out_selected_count (out_selected_count),
    .out_any_selected   (out_any_selected),
    .out_all_selected   (out_all_selected),
    .out_end_of_run     (out_end_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror and run state of the compactor
  logic [sblc_pkg::ROW_W-1:0] rows_reg = '0;
  logic [sblc_pkg::ROW_W-1:0] limit_reg = 16'hFFFF;
  logic                       emit_reg = 1'b1;
  logic [sblc_pkg::POS_W-1:0] byte_pos = '0;
  logic                       pos_ovf = 1'b0;
  logic [sblc_pkg::ROW_W-1:0] budget = 16'hFFFF;
  logic [sblc_pkg::ROW_W-1:0] kept_total = '0;

  bitmap_word_t  bitmap_q[$];
  compact_word_t compacted_q[$];

  int in_idle_max = 9;
  int out_idle_max = 9;
  int in_wait = 0;
  int out_wait = 0;
  int errors = 0;
  int quiet = 0;

  task automatic compact_byte(input logic [sblc_pkg::BYTE_BITS-1:0] bits,
                              input logic is_last);
    int base;
    int row;
    int n;
    logic [sblc_pkg::BYTE_BITS-1:0] kept;
    compact_word_t words[10];
    kept = '0;
    n = 0;
    if (byte_pos == '0 && !pos_ovf) budget = limit_reg;
    base = int'(byte_pos) * sblc_pkg::BYTE_BITS;
    if (!pos_ovf) begin
      for (int i = 0; i < sblc_pkg::BYTE_BITS; i++) begin
        row = base + i;
        if (bits[i] && row < int'(rows_reg) && budget != '0) begin
          kept[i] = 1'b1;
          budget = budget - 1'b1;
          if (kept_total != 16'hFFFF) kept_total = kept_total + 1'b1;
        end
      end
    end
    words[n] = '0;
    words[n].kind = sblc_pkg::KIND_BYTE;
    words[n].kept_byte = kept;
    n++;
    if (emit_reg) begin
      for (int i = 0; i < sblc_pkg::BYTE_BITS; i++) begin
        if (kept[i]) begin
          words[n] = '0;
          words[n].kind = sblc_pkg::KIND_INDEX;
          words[n].row_index = 16'(base + i);
          n++;
        end
      end
    end
    if (byte_pos != sblc_pkg::LAST_POS) byte_pos = byte_pos + 1'b1;
    else pos_ovf = 1'b1;
    if (is_last) begin
      words[n] = '0;
      words[n].kind = sblc_pkg::KIND_SUMMARY;
      words[n].selected_count = kept_total;
      words[n].any_selected = (kept_total != '0);
      words[n].all_selected = (kept_total == rows_reg);
      n++;
      byte_pos = '0;
      kept_total = '0;
      pos_ovf = 1'b0;
    end
    words[n-1].end_of_run = 1'b1;
    for (int i = 0; i < n; i++) compacted_q.push_back(words[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bitmap_word_t w;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_wait = 0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        compact_byte(in_bitmap_byte, in_last);
        in_wait = $urandom_range(0, in_idle_max);
      end
      if (in_wait != 0) begin
        in_wait--;
        in_push <= 1'b0;
      end else if (bitmap_q.size() != 0) begin
        w = bitmap_q.pop_front();
        in_bitmap_byte <= w.bits;
        in_last <= w.last;
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    compact_word_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (compacted_q.size() == 0) begin
          $display("%0t: word with nothing expected: kind %0d kept %0d row %0d count %0d",
                   $time, out_kind, out_kept_byte, out_row_index, out_selected_count);
          errors++;
        end else begin
          want = compacted_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("kept_byte", want.kept_byte, out_kept_byte);
          check_field("row_index", want.row_index, out_row_index);
          check_field("selected_count", want.selected_count, out_selected_count);
          check_field("any_selected", want.any_selected, out_any_selected);
          check_field("all_selected", want.all_selected, out_all_selected);
          check_field("end_of_run", want.end_of_run, out_end_of_run);
        end
        out_wait = $urandom_range(0, out_idle_max);
      end
      if (out_wait != 0) begin
        out_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("** selection_bitmap_limit_compact: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_byte(input logic [sblc_pkg::BYTE_BITS-1:0] bits, input logic is_last);
    bitmap_word_t w;
    w.bits = bits;
    w.last = is_last;
    bitmap_q.push_back(w);
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (bitmap_q.size() != 0 || in_push || compacted_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [sblc_pkg::ROW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      sblc_pkg::CFG_ROW_COUNT:    rows_reg = val;
      sblc_pkg::CFG_SELECT_LIMIT: limit_reg = val;
      sblc_pkg::CFG_EMIT_INDICES: emit_reg = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int run_left;
    logic [sblc_pkg::BYTE_BITS-1:0] bits;
    logic last;
    run_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty bitmap under reset settings
    queue_byte(8'hFF, 1'b1);
    wait_drain();

    write_reg(sblc_pkg::CFG_ROW_COUNT, 16'd20);
    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'hFFFF);
    write_reg(sblc_pkg::CFG_EMIT_INDICES, 16'h0001);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h80, 1'b1);
    wait_drain();

    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'd5);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_drain();

    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'd0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h5A, 1'b1);
    wait_drain();

    // change registers in the middle of a run
    write_reg(sblc_pkg::CFG_ROW_COUNT, 16'd16);
    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'd10);
    queue_byte(8'h0F, 1'b0);
    wait_drain();
    write_reg(sblc_pkg::CFG_ROW_COUNT, 16'd12);
    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'd0);
    write_reg(sblc_pkg::CFG_EMIT_INDICES, 16'hFFFE);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b1);
    wait_drain();

    // widest row count, indices off then on
    write_reg(sblc_pkg::CFG_ROW_COUNT, 16'hFFFF);
    write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'hFFFF);
    in_idle_max = 2;
    out_idle_max = 2;
    repeat (3) queue_byte(8'hFF, 1'b0);
    wait_drain();
    write_reg(sblc_pkg::CFG_EMIT_INDICES, 16'h0001);
    repeat (2) queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h3C, 1'b1);
    wait_drain();

    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 9))
        0: write_reg(sblc_pkg::CFG_ROW_COUNT, 16'd0);
        1: write_reg(sblc_pkg::CFG_ROW_COUNT, 16'hFFFF);
        2: write_reg(sblc_pkg::CFG_ROW_COUNT, 16'($urandom));
        default: write_reg(sblc_pkg::CFG_ROW_COUNT, 16'($urandom_range(1, 72)));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'd0);
        1: write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'hFFFF);
        2: write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'($urandom));
        default: write_reg(sblc_pkg::CFG_SELECT_LIMIT, 16'($urandom_range(1, 30)));
      endcase
      write_reg(sblc_pkg::CFG_EMIT_INDICES, 16'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNMAPPED, 16'($urandom));
      in_idle_max = $urandom_range(0, 1) ? 9 : 0;
      out_idle_max = $urandom_range(0, 1) ? 9 : 0;
      for (int k = 0; k < 22; k++) begin
        if (run_left == 0) run_left = $urandom_range(1, 8);
        case ($urandom_range(0, 5))
          0: bits = 8'hFF;
          1: bits = 8'h00;
          2: bits = 8'h01 << $urandom_range(0, 7);
          default: bits = 8'($urandom);
        endcase
        last = (run_left == 1);
        if ($urandom_range(0, 9) == 0) last = $urandom_range(0, 1);
        run_left = last ? 0 : run_left - 1;
        queue_byte(bits, last);
      end
      wait_drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** selection_bitmap_limit_compact: PASSED **");
    end else begin
      $display("** selection_bitmap_limit_compact: FAILED **");
    end
    $finish;
  end

endmodule
